FILE: rtl/ctle_pkg.sv
// ----------------------------------------------------------------------------
// Chunk table lookup engine package
// Shared constants, codes and word types for the chunk table lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ctle_pkg;

    localparam int LIVE_DEPTH    = 64;
    localparam int PENDING_DEPTH = 64;

    localparam int LIVE_AW = $clog2(LIVE_DEPTH);
    localparam int PEND_AW = $clog2(PENDING_DEPTH);
    localparam int LIVE_CW = $clog2(LIVE_DEPTH + 1);
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
    localparam int CNT_W   = (LIVE_CW > PEND_CW) ? LIVE_CW : PEND_CW;
    localparam int SUM_W   = CNT_W + 1;

    // Command kinds.
    localparam logic [2:0] KIND_APPEND      = 3'd0;
    localparam logic [2:0] KIND_COMMIT      = 3'd1;
    localparam logic [2:0] KIND_REPLACE     = 3'd2;
    localparam logic [2:0] KIND_CLEAR_LIVE  = 3'd3;
    localparam logic [2:0] KIND_CLEAR_PEND  = 3'd4;
    localparam logic [2:0] KIND_FIND_LATEST = 3'd5;
    localparam logic [2:0] KIND_FIND_MATCH  = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_LIVE_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NO_MATCH      = 3'd2;
    localparam logic [2:0] ST_PENDING_EMPTY = 3'd3;
    localparam logic [2:0] ST_FULL          = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [39:0] first_byte;
        logic [39:0] last_byte;
        logic [31:0] stamp;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] entry_index;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [39:0] first_byte;
        logic [39:0] last_byte;
        logic [31:0] stamp;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // Flags from the shared record compare unit.
    typedef struct packed {
        logic range_eq;
        logic peer_eq;
        logic newer;
    } match_t;

endpackage

`default_nettype wire

FILE: rtl/ctle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ctle_match.sv
// ----------------------------------------------------------------------------
// Record compare unit
// Compares one stored record with the query and the best stamp so far.
// ----------------------------------------------------------------------------
`default_nettype none

module ctle_match (
    input  wire ctle_pkg::rec_t entry,
    input  wire ctle_pkg::rec_t query,
    input  wire logic [31:0]    best,
    output ctle_pkg::match_t    flags
);

    always_comb
    begin
        flags.range_eq = (entry.first_byte == query.first_byte) &&
                         (entry.last_byte == query.last_byte);
        flags.peer_eq  = (entry.peer_addr == query.peer_addr) &&
                         (entry.peer_port == query.peer_port);
        flags.newer    = entry.stamp > best;
    end

endmodule

`default_nettype wire

FILE: rtl/chunk_table_lookup_engine.sv
// ----------------------------------------------------------------------------
// Chunk table lookup engine
// Live and pending chunk record tables with append, commit, clear and search.
// ----------------------------------------------------------------------------
// A command word enters on req (req_valid/req_ready) and exactly one result
// word leaves on rsp (rsp_valid/rsp_ready) for every command taken.
// req_ready is high only while the sequencer is idle, so one command is in
// work at a time; the next may be taken while the previous result word still
// waits in the output register.
// Append, clear and rejected commands go from idle straight to the finish
// state, which loads their result word into the output register. Commit and
// replace walk the pending table one record a cycle through the pending RAM
// read port into the live RAM, then finish. Find-latest and find-match walk
// the live table one record a cycle through the live RAM read port and the
// one shared compare unit, then finish. Once a result word is loaded the
// sequencer is idle again and can take the next command.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register is free; nothing is dropped.
// Reset empties both tables by zeroing their counts; the table memories are
// not cleared, as entries beyond the counts are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_table_lookup_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire ctle_pkg::req_word_t   req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output ctle_pkg::rsp_word_t        rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COPY   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Table occupancy.
    logic [ctle_pkg::LIVE_CW-1:0] live_count_reg, live_count_next;
    logic [ctle_pkg::PEND_CW-1:0] pend_count_reg, pend_count_next;

    // Walk control: issue counter, limit, and the read in flight.
    logic [ctle_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [ctle_pkg::CNT_W-1:0]   lim_reg, lim_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [ctle_pkg::CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ctle_pkg::LIVE_CW-1:0] base_reg, base_next;

    // Command held for the duration of the walk.
    logic [2:0]                   op_reg, op_next;
    ctle_pkg::req_word_t          query_reg, query_next;

    // Search result accumulation.
    logic [31:0]                  best_reg, best_next;
    logic                         hit_reg, hit_next;
    logic [ctle_pkg::CNT_W-1:0]   at_reg, at_next;
    logic [2:0]                   status_reg, status_next;

    // Output register.
    ctle_pkg::rsp_word_t          rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    // RAM ports.
    logic                         pend_we, pend_re, live_we, live_re;
    ctle_pkg::rec_t               pend_wdata, pend_rdata, live_rdata;
    ctle_pkg::rec_t               query_rec;
    ctle_pkg::match_t             flags;
    logic [ctle_pkg::SUM_W-1:0]   live_wsum;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pend_wdata.peer_addr  = req.peer_addr;
    assign pend_wdata.peer_port  = req.peer_port;
    assign pend_wdata.first_byte = req.first_byte;
    assign pend_wdata.last_byte  = req.last_byte;
    assign pend_wdata.stamp      = req.stamp;

    assign query_rec.peer_addr  = query_reg.peer_addr;
    assign query_rec.peer_port  = query_reg.peer_port;
    assign query_rec.first_byte = query_reg.first_byte;
    assign query_rec.last_byte  = query_reg.last_byte;
    assign query_rec.stamp      = query_reg.stamp;

    // Live write address during a copy: the copy base plus the record index.
    assign live_wsum = ctle_pkg::SUM_W'(base_reg) + ctle_pkg::SUM_W'(rd_idx_reg);

    ctle_ram #(
        .WIDTH (ctle_pkg::REC_W),
        .DEPTH (ctle_pkg::PENDING_DEPTH)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (ctle_pkg::PEND_AW'(pend_count_reg)),
        .wdata (pend_wdata),
        .re    (pend_re),
        .raddr (ctle_pkg::PEND_AW'(idx_reg)),
        .rdata (pend_rdata)
    );

    ctle_ram #(
        .WIDTH (ctle_pkg::REC_W),
        .DEPTH (ctle_pkg::LIVE_DEPTH)
    ) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (ctle_pkg::LIVE_AW'(live_wsum)),
        .wdata (pend_rdata),
        .re    (live_re),
        .raddr (ctle_pkg::LIVE_AW'(idx_reg)),
        .rdata (live_rdata)
    );

    ctle_match u_match (
        .entry (live_rdata),
        .query (query_rec),
        .best  (best_reg),
        .flags (flags)
    );

    always_comb
    begin
        state_next      = state_reg;
        live_count_next = live_count_reg;
        pend_count_next = pend_count_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = idx_reg;
        base_next       = base_reg;
        op_next         = op_reg;
        query_next      = query_reg;
        best_next       = best_reg;
        hit_next        = hit_reg;
        at_next         = at_reg;
        status_next     = status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        pend_we         = 1'b0;
        pend_re         = 1'b0;
        live_we         = 1'b0;
        live_re         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    query_next  = req;
                    op_next     = req.kind;
                    idx_next    = '0;
                    best_next   = '0;
                    hit_next    = 1'b0;
                    at_next     = '0;
                    status_next = ctle_pkg::ST_OK;
                    state_next  = S_FINISH;
                    case (req.kind)
                        ctle_pkg::KIND_APPEND:
                        begin
                            if (pend_count_reg >=
                                ctle_pkg::PEND_CW'(ctle_pkg::PENDING_DEPTH))
                            begin
                                status_next = ctle_pkg::ST_FULL;
                            end
                            else
                            begin
                                pend_we         = 1'b1;
                                pend_count_next = pend_count_reg + 1'b1;
                            end
                        end
                        ctle_pkg::KIND_COMMIT:
                        begin
                            if (pend_count_reg == '0)
                            begin
                                status_next = ctle_pkg::ST_PENDING_EMPTY;
                            end
                            else if (ctle_pkg::SUM_W'(live_count_reg) +
                                     ctle_pkg::SUM_W'(pend_count_reg) >
                                     ctle_pkg::SUM_W'(ctle_pkg::LIVE_DEPTH))
                            begin
                                status_next = ctle_pkg::ST_FULL;
                            end
                            else
                            begin
                                base_next  = live_count_reg;
                                lim_next   = ctle_pkg::CNT_W'(pend_count_reg);
                                state_next = S_COPY;
                            end
                        end
                        ctle_pkg::KIND_REPLACE:
                        begin
                            if (pend_count_reg == '0)
                            begin
                                status_next = ctle_pkg::ST_PENDING_EMPTY;
                            end
                            else if (ctle_pkg::SUM_W'(pend_count_reg) >
                                     ctle_pkg::SUM_W'(ctle_pkg::LIVE_DEPTH))
                            begin
                                status_next = ctle_pkg::ST_FULL;
                            end
                            else
                            begin
                                base_next  = '0;
                                lim_next   = ctle_pkg::CNT_W'(pend_count_reg);
                                state_next = S_COPY;
                            end
                        end
                        ctle_pkg::KIND_CLEAR_LIVE:
                        begin
                            live_count_next = '0;
                        end
                        ctle_pkg::KIND_CLEAR_PEND:
                        begin
                            pend_count_next = '0;
                        end
                        ctle_pkg::KIND_FIND_LATEST:
                        begin
                            if (live_count_reg == '0)
                            begin
                                status_next = ctle_pkg::ST_LIVE_EMPTY;
                            end
                            else
                            begin
                                lim_next   = ctle_pkg::CNT_W'(live_count_reg);
                                state_next = S_SCAN;
                            end
                        end
                        ctle_pkg::KIND_FIND_MATCH:
                        begin
                            if (live_count_reg == '0)
                            begin
                                status_next = ctle_pkg::ST_NO_MATCH;
                            end
                            else
                            begin
                                lim_next   = ctle_pkg::CNT_W'(live_count_reg);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ctle_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one live read per cycle; judge the record read last cycle.
                if (idx_reg != lim_reg)
                begin
                    live_re       = 1'b1;
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (op_reg == ctle_pkg::KIND_FIND_LATEST)
                    begin
                        if (flags.range_eq && flags.newer)
                        begin
                            best_next = live_rdata.stamp;
                            at_next   = rd_idx_reg;
                            hit_next  = 1'b1;
                        end
                    end
                    else if (!hit_reg && flags.range_eq && flags.peer_eq)
                    begin
                        at_next  = rd_idx_reg;
                        hit_next = 1'b1;
                    end
                end
                else if (idx_reg == lim_reg)
                begin
                    status_next = hit_reg ? ctle_pkg::ST_OK : ctle_pkg::ST_NO_MATCH;
                    state_next  = S_FINISH;
                end
            end

            S_COPY:
            begin
                // Read pending one record a cycle and write it to live in the cycle after its read.
                if (idx_reg != lim_reg)
                begin
                    pend_re       = 1'b1;
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    live_we = 1'b1;
                end
                else if (idx_reg == lim_reg)
                begin
                    live_count_next = ctle_pkg::LIVE_CW'(
                        ctle_pkg::SUM_W'(base_reg) + ctle_pkg::SUM_W'(lim_reg));
                    pend_count_next = '0;
                    status_next     = ctle_pkg::ST_OK;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.entry_index = 6'(at_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            pend_count_reg <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            pend_count_reg <= pend_count_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg    <= lim_next;
        rd_idx_reg <= rd_idx_next;
        base_reg   <= base_next;
        op_reg     <= op_next;
        query_reg  <= query_next;
        best_reg   <= best_next;
        hit_reg    <= hit_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: rtl/ctle_checker.sv
// ----------------------------------------------------------------------------
// Chunk table lookup engine checker
// Port-level assertions on the command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ctle_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire ctle_pkg::rsp_word_t rsp
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // Every command leaves the idle state when taken, so the engine is busy after a take.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while previous command still in work");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ctle_pkg::ST_FULL)
        else $error("undefined status code");

    // An index is only reported alongside a successful status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ctle_pkg::ST_OK |-> rsp.entry_index == '0)
        else $error("entry index set on a failed command");

endmodule

bind chunk_table_lookup_engine ctle_checker u_ctle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
